// ===== design/array_list_insert_delete_search_assert.svh =====
// Assertion macros for the list block. Define ASSERT_OFF to drop them.
`ifndef ARRAY_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF

// ante holds -> cons holds in the same cycle
`define ALIDS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define ALIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ALIDS_ASSERT_IMPL(lbl, ante, cons, msg)
`define ALIDS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/alids_pkg.sv =====
package alids_pkg;

  localparam int unsigned DEPTH    = 128;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LOC_W    = 8;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int unsigned RES_W       = STATUS_W + 1 + LOC_W + 1 + LOC_W;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned IN_TDATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_SEARCH = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_BIN
  } state_e;

  // broadcast to every cell; value is also the search key
  typedef struct packed {
    cell_op_e                op;
    logic [IDX_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic eq;   // key equals entry
    logic gt;   // key greater than entry
    logic bad;  // entry greater than right neighbour
  } cell_flags_t;

  typedef struct packed {
    logic [DEPTH-1:0] eq;
    logic [DEPTH-1:0] gt;
    logic [DEPTH-1:0] bad;
  } row_flags_t;

  // first member in the top bits, so status sits lowest
  typedef struct packed {
    logic [LOC_W-1:0] entry_count;
    logic             used_binary;
    logic [LOC_W-1:0] location;
    logic             found;
    status_e          status;
  } result_t;

endpackage

// ===== design/array_list_insert_delete_search.sv =====
// Ordered list of up to DEPTH (128) signed 32-bit words with a running count.
// Each input transfer carries one operation in s_axis_tuser (clear, append,
// insert at position, delete at position, search) and yields exactly one
// result transfer with a status, the search outcome and the new count.
// The words live in a row of cells; insert and delete shift the whole tail
// one place at once. A search first walks the cells one entry a cycle to
// check order and find the first match, then, if the list is ascending,
// runs a binary search at one probe a cycle, a miss ending on the empty
// window. One operation is handled at a time; the next input transfer is
// taken once the result register is free or being drained.
// Entries past the count are never read, so the word store needs no clearing
// after reset. Kinds 5 to 7 do nothing and report ok.
module array_list_insert_delete_search (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] value (signed), [39:32] position
  input  logic [alids_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [2:0] kind
  input  logic [alids_pkg::KIND_W-1:0]          s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [1:0] status, [2] found, [10:3] location, [11] used_binary,
  // [19:12] entry_count, rest zero
  output logic [alids_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned D = alids_pkg::DEPTH;

  logic signed [alids_pkg::VAL_W-1:0] cell_val [D];
  alids_pkg::cell_flags_t             cell_flg [D];
  alids_pkg::row_flags_t              row_flags;
  alids_pkg::cell_cmd_t               cmd;
  alids_pkg::result_t                 result;
  logic                               in_ready;

  // sequencer: count, scan, binary search, result register
  alids_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (in_ready),
    .kind_i      (s_axis_tuser),
    .value_i     (s_axis_tdata[alids_pkg::VAL_W-1:0]),
    .position_i  (s_axis_tdata[alids_pkg::VAL_W +: alids_pkg::POS_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result),
    .cmd_o       (cmd),
    .flags_i     (row_flags)
  );

  // row of cells; each sees both neighbours, the ends see themselves
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [alids_pkg::VAL_W-1:0] left_val, right_val;

    if (i == 0) begin : g_first
      assign left_val = cell_val[i];
    end else begin : g_inner_l
      assign left_val = cell_val[i-1];
    end

    if (i == D - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner_r
      assign right_val = cell_val[i+1];
    end

    alids_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (alids_pkg::IDX_W'(i)),
      .cmd_i   (cmd),
      .left_i  (left_val),
      .right_i (right_val),
      .value_o (cell_val[i]),
      .flags_o (cell_flg[i])
    );

    assign row_flags.eq[i]  = cell_flg[i].eq;
    assign row_flags.gt[i]  = cell_flg[i].gt;
    assign row_flags.bad[i] = cell_flg[i].bad;
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tdata  = alids_pkg::OUT_TDATA_W'(result);

endmodule

// ===== design/alids_cell.sv =====
module alids_cell (
  input  logic                                  clk_i,
  input  logic [alids_pkg::IDX_W-1:0]           idx_i,
  input  alids_pkg::cell_cmd_t                  cmd_i,
  input  logic signed [alids_pkg::VAL_W-1:0]    left_i,
  input  logic signed [alids_pkg::VAL_W-1:0]    right_i,
  output logic signed [alids_pkg::VAL_W-1:0]    value_o,
  output alids_pkg::cell_flags_t                flags_o
);

  logic signed [alids_pkg::VAL_W-1:0] value_q, value_d;
  alids_pkg::cell_flags_t             flags_q, flags_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      alids_pkg::CELL_INSERT: begin
        if (idx_i == cmd_i.pos) begin
          value_d = cmd_i.value;
        end else if (idx_i > cmd_i.pos) begin
          value_d = left_i;
        end
      end
      alids_pkg::CELL_DELETE: begin
        if (idx_i >= cmd_i.pos) begin
          value_d = right_i;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    flags_d.eq  = (value_q == cmd_i.value);
    flags_d.gt  = (cmd_i.value > value_q);
    flags_d.bad = (value_q > right_i);
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    flags_q <= flags_d;
  end

  assign value_o = value_q;
  assign flags_o = flags_q;

endmodule

// ===== design/alids_seq.sv =====
`include "array_list_insert_delete_search_assert.svh"

module alids_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [alids_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [alids_pkg::VAL_W-1:0]  value_i,
  input  logic [alids_pkg::POS_W-1:0]         position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output alids_pkg::result_t                  result_o,
  output alids_pkg::cell_cmd_t                cmd_o,
  input  alids_pkg::row_flags_t               flags_i
);

  localparam int unsigned CW = alids_pkg::CNT_W;
  localparam int unsigned IW = alids_pkg::IDX_W;

  alids_pkg::state_e                  state_q, state_d;
  logic [alids_pkg::KIND_W-1:0]       kind_q, kind_d;
  logic signed [alids_pkg::VAL_W-1:0] val_q, val_d;
  logic [alids_pkg::POS_W-1:0]        pos_q, pos_d;
  logic [CW-1:0]                      count_q, count_d;
  logic [IW-1:0]                      idx_q, idx_d;
  logic                               asc_q, asc_d;
  logic                               hit_q, hit_d;
  logic [CW-1:0]                      loc_q, loc_d;
  logic [CW-1:0]                      lo_q, lo_d;
  logic [CW-1:0]                      hx_q, hx_d;
  logic                               out_valid_q;
  alids_pkg::result_t                 res_q, res_d;

  logic                               accept;
  logic                               out_load;
  logic                               scan_last;
  logic                               bin_done;
  logic                               full;
  logic [alids_pkg::CMP_W-1:0]        pos_ext, cnt_ext;
  logic [CW-1:0]                      idx_nxt;
  logic [CW:0]                        mid_sum;
  logic [IW-1:0]                      mid;

  assign in_ready_o = (state_q == alids_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign full    = (count_q >= CW'(alids_pkg::DEPTH));
  assign pos_ext = alids_pkg::CMP_W'(pos_q);
  assign cnt_ext = alids_pkg::CMP_W'(count_q);
  assign idx_nxt = CW'(idx_q) + CW'(1);
  assign mid_sum = (CW + 1)'(lo_q) + (CW + 1)'(hx_q) - (CW + 1)'(1);
  assign mid     = mid_sum[IW:1];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      alids_pkg::S_IDLE: begin
        if (accept) begin
          state_d = alids_pkg::S_EXEC;
        end
      end
      alids_pkg::S_EXEC: begin
        if ((kind_q == alids_pkg::KIND_SEARCH) && (count_q != '0)) begin
          state_d = alids_pkg::S_SCAN;
        end else begin
          state_d = alids_pkg::S_IDLE;
        end
      end
      alids_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = asc_d ? alids_pkg::S_BIN : alids_pkg::S_IDLE;
        end
      end
      alids_pkg::S_BIN: begin
        if (bin_done) begin
          state_d = alids_pkg::S_IDLE;
        end
      end
      default: state_d = alids_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d    = kind_q;
    val_d     = val_q;
    pos_d     = pos_q;
    count_d   = count_q;
    idx_d     = idx_q;
    asc_d     = asc_q;
    hit_d     = hit_q;
    loc_d     = loc_q;
    lo_d      = lo_q;
    hx_d      = hx_q;
    res_d     = res_q;
    out_load  = 1'b0;
    scan_last = 1'b0;
    bin_done  = 1'b0;
    cmd_o.op    = alids_pkg::CELL_HOLD;
    cmd_o.pos   = pos_q[IW-1:0];
    cmd_o.value = val_q;

    case (state_q)
      alids_pkg::S_IDLE: begin
        if (accept) begin
          kind_d = kind_i;
          val_d  = value_i;
          pos_d  = position_i;
        end
      end

      alids_pkg::S_EXEC: begin
        res_d.status      = alids_pkg::ST_OK;
        res_d.found       = 1'b0;
        res_d.location    = '0;
        res_d.used_binary = 1'b0;
        out_load          = 1'b1;
        case (alids_pkg::kind_e'(kind_q))
          alids_pkg::KIND_CLEAR: begin
            count_d = '0;
          end
          alids_pkg::KIND_APPEND: begin
            if (full) begin
              res_d.status = alids_pkg::ST_FULL;
            end else begin
              cmd_o.op  = alids_pkg::CELL_INSERT;
              cmd_o.pos = count_q[IW-1:0];
              count_d   = count_q + CW'(1);
            end
          end
          alids_pkg::KIND_INSERT: begin
            if (full) begin
              res_d.status = alids_pkg::ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              res_d.status = alids_pkg::ST_RANGE;
            end else begin
              cmd_o.op = alids_pkg::CELL_INSERT;
              count_d  = count_q + CW'(1);
            end
          end
          alids_pkg::KIND_DELETE: begin
            if (count_q == '0) begin
              res_d.status = alids_pkg::ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
              res_d.status = alids_pkg::ST_RANGE;
            end else begin
              cmd_o.op = alids_pkg::CELL_DELETE;
              count_d  = count_q - CW'(1);
            end
          end
          alids_pkg::KIND_SEARCH: begin
            if (count_q == '0) begin
              res_d.status = alids_pkg::ST_EMPTY;
            end else begin
              // cells register their compare flags during this cycle
              out_load = 1'b0;
              idx_d    = '0;
              asc_d    = 1'b1;
              hit_d    = 1'b0;
              loc_d    = '0;
            end
          end
          default: ;
        endcase
        res_d.entry_count = alids_pkg::LOC_W'(count_d);
      end

      alids_pkg::S_SCAN: begin
        // one entry a cycle: order check and first match
        if ((idx_nxt < count_q) && flags_i.bad[idx_q]) begin
          asc_d = 1'b0;
        end
        if (flags_i.eq[idx_q] && !hit_q) begin
          hit_d = 1'b1;
          loc_d = idx_nxt;
        end
        idx_d     = idx_q + IW'(1);
        scan_last = (idx_nxt == count_q);
        if (scan_last) begin
          lo_d = '0;
          hx_d = count_q;
          if (!asc_d) begin
            out_load          = 1'b1;
            res_d.status      = alids_pkg::ST_OK;
            res_d.found       = hit_d;
            res_d.location    = alids_pkg::LOC_W'(loc_d);
            res_d.used_binary = 1'b0;
            res_d.entry_count = alids_pkg::LOC_W'(count_q);
          end
        end
      end

      alids_pkg::S_BIN: begin
        // window is [lo, hx), hx exclusive
        if (lo_q >= hx_q) begin
          bin_done = 1'b1;
          hit_d    = 1'b0;
          loc_d    = '0;
        end else if (flags_i.eq[mid]) begin
          bin_done = 1'b1;
          hit_d    = 1'b1;
          loc_d    = CW'(mid) + CW'(1);
        end else if (flags_i.gt[mid]) begin
          lo_d = CW'(mid) + CW'(1);
        end else begin
          hx_d = CW'(mid);
        end
        if (bin_done) begin
          out_load          = 1'b1;
          res_d.status      = alids_pkg::ST_OK;
          res_d.found       = hit_d;
          res_d.location    = alids_pkg::LOC_W'(loc_d);
          res_d.used_binary = 1'b1;
          res_d.entry_count = alids_pkg::LOC_W'(count_q);
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alids_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    asc_q  <= asc_d;
    hit_q  <= hit_d;
    loc_q  <= loc_d;
    lo_q   <= lo_d;
    hx_q   <= hx_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `ALIDS_ASSERT_IMPL(a_count_max, 1'b1, count_q <= CW'(alids_pkg::DEPTH), "count above depth")
  `ALIDS_ASSERT_IMPL(a_load_free, out_load, !out_valid_q, "result overwrites pending result")
  `ALIDS_ASSERT_NEXT(a_accept_exec, accept, state_q == alids_pkg::S_EXEC, "accept not executed")
  `ALIDS_ASSERT_IMPL(a_scan_range, state_q == alids_pkg::S_SCAN, idx_nxt <= count_q, "scan past end")
  `ALIDS_ASSERT_IMPL(a_bin_window, state_q == alids_pkg::S_BIN, (hx_q <= count_q) && (lo_q <= hx_q), "bad search window")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the list block: an in-bench model of the list
// predicts every result, and a checker compares each result transfer with
// the oldest prediction, field by field.
module tb;

  localparam int unsigned ITEM_TARGET    = 1050;  // list operations to send
  localparam int unsigned HOLD_CYCLES    = 400;   // long result back-pressure
  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles without any transfer
  localparam int unsigned SETTLE_CYCLES  = 200;   // longer than a full search

  localparam logic signed [alids_pkg::VAL_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [alids_pkg::VAL_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic [alids_pkg::POS_W-1:0]        POS_TOP  = '1;

  // kinds the block ignores: 5 up to the top code
  localparam logic [alids_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [alids_pkg::KIND_W-1:0] KIND_SPARE_LAST  = '1;

  logic                              clk_i;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  // [31:0] value, [39:32] position
  logic [alids_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [alids_pkg::KIND_W-1:0]      s_axis_tuser  = '0;  // [2:0] kind
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // status, found, location, used_binary, entry_count
  logic [alids_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  array_list_insert_delete_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Bench-side copy of the list and the results it still owes
  // ---------------------------------------------------------------------------
  logic signed [alids_pkg::VAL_W-1:0] list_words [alids_pkg::DEPTH];
  int unsigned                        list_count = 0;
  alids_pkg::result_t                 pending_results [$];

  // pacing controls, written by the tests only
  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned hold_serial  = 0;  // bump to ask the sink for one long hold-off

  // bookkeeping
  int unsigned errors          = 0;
  int unsigned ops_sent        = 0;
  int unsigned results_checked = 0;
  int unsigned binary_searches = 0;
  int unsigned linear_searches = 0;
  int unsigned status_hits [4] = '{default: 0};
  int unsigned largest_list    = 0;

  // Applies one operation to the bench list and returns the result it owes.
  function automatic alids_pkg::result_t apply_list_op(
      logic [alids_pkg::KIND_W-1:0] kind,
      logic signed [alids_pkg::VAL_W-1:0] value,
      logic [alids_pkg::POS_W-1:0] pos);
    alids_pkg::result_t res;
    int unsigned        loc;
    int unsigned        i;
    bit                 ascending;
    int                 lo, hi, mid;
    res = '0;
    res.status = alids_pkg::ST_OK;
    loc = 0;
    case (kind)
      alids_pkg::KIND_CLEAR: begin
        list_count = 0;
      end
      alids_pkg::KIND_APPEND: begin
        if (list_count >= alids_pkg::DEPTH) begin
          res.status = alids_pkg::ST_FULL;
        end else begin
          list_words[list_count] = value;
          list_count++;
        end
      end
      alids_pkg::KIND_INSERT: begin
        // full wins over a bad position
        if (list_count >= alids_pkg::DEPTH) begin
          res.status = alids_pkg::ST_FULL;
        end else if (pos > list_count) begin
          res.status = alids_pkg::ST_RANGE;
        end else begin
          for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = value;
          list_count++;
        end
      end
      alids_pkg::KIND_DELETE: begin
        if (list_count == 0) begin
          res.status = alids_pkg::ST_EMPTY;
        end else if (pos >= list_count) begin
          res.status = alids_pkg::ST_RANGE;
        end else begin
          for (i = 32'(pos); i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
      alids_pkg::KIND_SEARCH: begin
        if (list_count == 0) begin
          res.status = alids_pkg::ST_EMPTY;
        end else begin
          ascending = 1'b1;
          for (i = 0; i + 1 < list_count; i++)
            if (list_words[i] > list_words[i+1]) ascending = 1'b0;
          if (ascending) begin
            // bisection over [0, count-1]; duplicates give whichever the
            // midpoints hit first
            res.used_binary = 1'b1;
            lo = 0;
            hi = int'(list_count) - 1;
            while (lo <= hi && loc == 0) begin
              mid = (lo + hi) / 2;
              if (list_words[mid] == value) loc = mid + 1;
              else if (value > list_words[mid]) lo = mid + 1;
              else hi = mid - 1;
            end
          end else begin
            // first match wins
            for (i = 0; i < list_count; i++)
              if (loc == 0 && list_words[i] == value) loc = i + 1;
          end
          res.found    = (loc != 0);
          res.location = loc[alids_pkg::LOC_W-1:0];
        end
      end
      default: ;  // spare kinds leave the list alone
    endcase
    res.entry_count = list_count[alids_pkg::LOC_W-1:0];
    return res;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Mostly a key held in the list (or one off it), else any word.
  function automatic logic signed [alids_pkg::VAL_W-1:0] pick_key();
    logic signed [alids_pkg::VAL_W-1:0] w;
    if (list_count != 0 && $urandom_range(0, 2) != 0) begin
      w = list_words[$urandom_range(0, list_count - 1)];
      case ($urandom_range(0, 3))
        0:       return w + 1;
        1:       return w - 1;
        default: return w;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly a position within or just at the end of the list, else any byte.
  function automatic logic [alids_pkg::POS_W-1:0] pick_pos();
    if ($urandom_range(0, 4) != 0)
      return alids_pkg::POS_W'($urandom_range(0, list_count));
    return alids_pkg::POS_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call, entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_op(logic [alids_pkg::KIND_W-1:0] kind,
                         logic signed [alids_pkg::VAL_W-1:0] value,
                         logic [alids_pkg::POS_W-1:0] pos);
    int unsigned        gap;
    alids_pkg::result_t want;
    gap = src_idle_en ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, value};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    want = apply_list_op(kind, value, pos);
    pending_results.push_back(want);
    if (kind <= alids_pkg::KIND_SEARCH) ops_sent++;
    if (kind == alids_pkg::KIND_SEARCH && want.status == alids_pkg::ST_OK) begin
      if (want.used_binary) binary_searches++;
      else linear_searches++;
    end
    status_hits[want.status]++;
    if (list_count > largest_list) largest_list = list_count;
    @(negedge clk_i);
  endtask

  // Sender goes quiet until every owed result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Appends n words, each no smaller than the last one in the list.
  task automatic append_ascending(int unsigned n);
    logic signed [alids_pkg::VAL_W-1:0] w;
    longint                             nxt;
    longint                             step;
    w = (list_count != 0) ? list_words[list_count - 1]
                          : WORD_MIN + $urandom_range(0, 1 << 16);
    repeat (n) begin
      step = ($urandom_range(0, 3) == 0) ? 64'sd0
                                         : longint'($urandom_range(1, 1 << 26));
      nxt  = longint'(w) + step;
      if (nxt > longint'(WORD_MAX)) nxt = longint'(WORD_MAX);
      w = nxt[alids_pkg::VAL_W-1:0];
      send_op(alids_pkg::KIND_APPEND, w, alids_pkg::POS_W'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready pacing with an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned seen_serial;
    int unsigned hold_left;
    int unsigned stall_left;
    seen_serial = 0;
    hold_left   = 0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_serial != seen_serial) begin
        seen_serial = hold_serial;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle_en) stall_left = idle_len();
      end
    end
  end

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // every result transfer against the oldest owed result
  always @(posedge clk_i) begin : result_check
    alids_pkg::result_t got;
    alids_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[alids_pkg::RES_W-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with none owed, expected nothing got %h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",      32'(want.status),      32'(got.status));
        check_field("found",       32'(want.found),       32'(got.found));
        check_field("location",    32'(want.location),    32'(got.location));
        check_field("used_binary", 32'(want.used_binary), 32'(got.used_binary));
        check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        results_checked++;
      end
    end
  end

  // a hang shows up as a long stretch with no transfer on either side
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still owed",
                 $time, quiet_cycles, pending_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases on a short list, free-running on both sides.
  task automatic test_directed_cases();
    int k;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_op(alids_pkg::KIND_SEARCH, '0, '0);          // search on empty list
    send_op(alids_pkg::KIND_DELETE, '0, '0);          // delete on empty list
    send_op(alids_pkg::KIND_INSERT, '0, 8'd1);        // insert past the end
    send_op(alids_pkg::KIND_INSERT, WORD_MAX, '0);    // insert at the end, empty
    send_op(alids_pkg::KIND_APPEND, WORD_MIN, POS_TOP);
    send_op(alids_pkg::KIND_SEARCH, WORD_MIN, '0);    // unsorted: linear scan
    send_op(alids_pkg::KIND_SEARCH, 32'sd5, '0);      // linear miss
    send_op(alids_pkg::KIND_INSERT, WORD_MIN, '0);    // min, max, min
    send_op(alids_pkg::KIND_DELETE, '1, POS_TOP);     // every position bit set
    send_op(alids_pkg::KIND_DELETE, '0, 8'd3);        // position equal to count
    send_op(alids_pkg::KIND_DELETE, '0, 8'd2);        // min, max
    send_op(alids_pkg::KIND_INSERT, '0, 8'd1);        // min, 0, max
    send_op(alids_pkg::KIND_INSERT, WORD_MAX, 8'd3);  // position equal to count
    send_op(alids_pkg::KIND_APPEND, WORD_MAX, '0);    // run of duplicates
    send_op(alids_pkg::KIND_SEARCH, WORD_MAX, '0);    // bisection over duplicates
    send_op(alids_pkg::KIND_SEARCH, WORD_MIN, '0);
    send_op(alids_pkg::KIND_SEARCH, -32'sd1, '0);     // bisection miss
    for (k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      send_op(alids_pkg::KIND_W'(k), $urandom, alids_pkg::POS_W'($urandom));
    send_op(alids_pkg::KIND_INSERT, '0, 8'd128);
    send_op(alids_pkg::KIND_CLEAR, '1, POS_TOP);
    send_op(alids_pkg::KIND_SEARCH, '0, '0);
    drain_results();
  endtask

  // Fill to the limit, poke the full cases, then break the order.
  task automatic test_full_list();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_op(alids_pkg::KIND_CLEAR, '0, '0);
    send_op(alids_pkg::KIND_APPEND, WORD_MIN, '0);
    append_ascending(alids_pkg::DEPTH - 2);
    send_op(alids_pkg::KIND_APPEND, WORD_MAX, '0);
    send_op(alids_pkg::KIND_APPEND, 32'sd1, '0);       // full
    send_op(alids_pkg::KIND_INSERT, 32'sd1, '0);       // full
    send_op(alids_pkg::KIND_INSERT, 32'sd1, 8'd200);   // full before range
    send_op(alids_pkg::KIND_SEARCH, WORD_MIN, '0);
    send_op(alids_pkg::KIND_SEARCH, WORD_MAX, '0);
    repeat (8) send_op(alids_pkg::KIND_SEARCH, pick_key(), alids_pkg::POS_W'($urandom));
    send_op(alids_pkg::KIND_DELETE, '0, 8'd127);       // last entry
    send_op(alids_pkg::KIND_INSERT, WORD_MAX, 8'd127); // back to full
    send_op(alids_pkg::KIND_DELETE, '0, '0);
    send_op(alids_pkg::KIND_INSERT, WORD_MIN, 8'd60);  // order broken: linear
    repeat (6) send_op(alids_pkg::KIND_SEARCH, pick_key(), alids_pkg::POS_W'($urandom));
    repeat (4) send_op(alids_pkg::KIND_DELETE, $urandom, pick_pos());
    send_op(alids_pkg::KIND_SEARCH, pick_key(), '0);
    send_op(alids_pkg::KIND_CLEAR, '0, '0);
    drain_results();
  endtask

  // Sink holds off for a long stretch while the sender keeps offering.
  task automatic test_result_stall();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_serial++;
    append_ascending(20);
    repeat (4) send_op(alids_pkg::KIND_SEARCH, pick_key(), '0);
    repeat (4) send_op(alids_pkg::KIND_INSERT, $urandom, pick_pos());
    send_op(alids_pkg::KIND_SEARCH, pick_key(), '0);
    drain_results();
  endtask

  // Mostly well-formed bursts (ordered builds, searches, edits), some noise.
  task automatic test_random_traffic();
    int unsigned choice;
    int unsigned run;
    int unsigned pick;
    while (ops_sent < ITEM_TARGET) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
        if ($urandom_range(0, 2) == 0)
          send_op(alids_pkg::KIND_CLEAR, $urandom, alids_pkg::POS_W'($urandom));
        // now and then build all the way up to full and beyond
        run = ($urandom_range(0, 19) == 0) ? alids_pkg::DEPTH : $urandom_range(1, 24);
        append_ascending(run);
        repeat ($urandom_range(2, 8))
          send_op(alids_pkg::KIND_SEARCH, pick_key(), alids_pkg::POS_W'($urandom));
      end else if (choice < 85) begin
        repeat ($urandom_range(3, 12)) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) send_op(alids_pkg::KIND_INSERT, $urandom, pick_pos());
          else if (pick < 6) send_op(alids_pkg::KIND_DELETE, $urandom, pick_pos());
          else if (pick < 7)
            send_op(alids_pkg::KIND_APPEND, $urandom, alids_pkg::POS_W'($urandom));
          else
            send_op(alids_pkg::KIND_SEARCH, pick_key(), alids_pkg::POS_W'($urandom));
        end
      end else begin
        repeat ($urandom_range(2, 8))
          send_op(alids_pkg::KIND_W'($urandom), $urandom, alids_pkg::POS_W'($urandom));
      end
      // keep most lists short so searches stay quick
      if (list_count > 48 && $urandom_range(0, 3) == 0)
        send_op(alids_pkg::KIND_CLEAR, $urandom, alids_pkg::POS_W'($urandom));
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed_cases();
    test_full_list();
    test_result_stall();
    test_random_traffic();

    // a stray late result would still be caught here
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d list operations, %0d results checked; %0d binary, %0d linear.",
             ops_sent, results_checked, binary_searches, linear_searches);
    $display("Status seen: full %0d, out of range %0d, empty %0d; longest list %0d.",
             status_hits[alids_pkg::ST_FULL], status_hits[alids_pkg::ST_RANGE],
             status_hits[alids_pkg::ST_EMPTY], largest_list);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
